[rtl/max_pool_2d_stream_core_defines.svh]
// assertion macros for the checker file of the max pooling core
// depends on nothing; included by bare file name
`ifndef MAX_POOL_2D_STREAM_CORE_DEFINES_SVH
`define MAX_POOL_2D_STREAM_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MP2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MP2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mp2d_pkg.sv]
// shared constants and types of the max pooling core
// no dependencies
package mp2d_pkg;

  // sizing
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned MAX_WIDTH    = 256;
  localparam int unsigned MAX_HEIGHT   = 1024;
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned MAX_POOL     = 8;

  // derived widths
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CHAN_W     = $clog2(MAX_CHANNELS);
  localparam int unsigned CHAN_CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned POOL_W     = $clog2(MAX_POOL + 1);
  localparam int unsigned WIN_W      = $clog2(MAX_POOL);
  localparam int unsigned OROW_W     = $clog2(MAX_HEIGHT);
  localparam int unsigned OCOL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned MEM_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned MEM_AW     = $clog2(MEM_DEPTH);

  // configuration port
  localparam int unsigned CFG_DW = 11;
  localparam int unsigned CFG_IW = 3;

  // result queue
  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OPTR_W    = $clog2(OUT_DEPTH);
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IW-1:0] {
    REG_IN_HEIGHT = 3'd0,
    REG_IN_WIDTH  = 3'd1,
    REG_CHANNELS  = 3'd2,
    REG_POOL_ROWS = 3'd3,
    REG_POOL_COLS = 3'd4
  } reg_idx_e;

  // effective (clamped) configuration
  typedef struct packed {
    logic [ROW_W-1:0]      height;
    logic [COL_W-1:0]      width;
    logic [CHAN_CNT_W-1:0] chans;
    logic [POOL_W-1:0]     prow;
    logic [POOL_W-1:0]     pcol;
  } cfg_t;

  // stream position of the current sample
  typedef struct packed {
    logic              in_win;
    logic              first;
    logic              last_win;
    logic              frame_end;
    logic [OROW_W-1:0] orow;
    logic [OCOL_W-1:0] ocol;
    logic [CHAN_W-1:0] chan;
  } pos_t;

  // one result item
  typedef struct packed {
    logic [DATA_W-1:0] pooled;
    logic [OROW_W-1:0] orow;
    logic [OCOL_W-1:0] ocol;
    logic [CHAN_W-1:0] chan;
    logic              frame_end;
  } res_t;

endpackage

[rtl/mp2d_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mp2d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mp2d_scan.sv]
// stream position tracker: row, column, channel and pooling window counters
// depends on mp2d_pkg
module mp2d_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mp2d_pkg::cfg_t cfg_i,
  input  logic          restart_i,
  input  logic          step_i,
  output mp2d_pkg::pos_t pos_o
);
  import mp2d_pkg::*;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic [WIN_W-1:0]  wrow_q, wrow_d;
  logic [WIN_W-1:0]  wcol_q, wcol_d;
  logic [OROW_W-1:0] orow_q, orow_d;
  logic [OCOL_W-1:0] ocol_q, ocol_d;
  logic [ROW_W-1:0]  rstart_q, rstart_d;
  logic [COL_W-1:0]  cstart_q, cstart_d;

  logic row_in, col_in, last_row, last_col;
  logic chan_last, col_last, row_last, wrow_last, wcol_last;

  // window fits inside the frame and is the last one on its axis
  assign row_in   = (rstart_q + ROW_W'(cfg_i.prow)) <= cfg_i.height;
  assign col_in   = (cstart_q + COL_W'(cfg_i.pcol)) <= cfg_i.width;
  assign last_row = (rstart_q + ROW_W'({cfg_i.prow, 1'b0})) > cfg_i.height;
  assign last_col = (cstart_q + COL_W'({cfg_i.pcol, 1'b0})) > cfg_i.width;

  // wrap conditions
  assign chan_last = (CHAN_CNT_W'(chan_q) + 1'b1) == cfg_i.chans;
  assign col_last  = (col_q + 1'b1) == cfg_i.width;
  assign row_last  = (row_q + 1'b1) == cfg_i.height;
  assign wrow_last = (POOL_W'(wrow_q) + 1'b1) == cfg_i.prow;
  assign wcol_last = (POOL_W'(wcol_q) + 1'b1) == cfg_i.pcol;

  assign pos_o.in_win    = row_in & col_in;
  assign pos_o.first     = (wrow_q == '0) && (wcol_q == '0);
  assign pos_o.last_win  = wrow_last & wcol_last;
  assign pos_o.frame_end = last_row & last_col & chan_last;
  assign pos_o.orow      = orow_q;
  assign pos_o.ocol      = ocol_q;
  assign pos_o.chan      = chan_q;

  // counter advance per sample
  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    chan_d   = chan_q;
    wrow_d   = wrow_q;
    wcol_d   = wcol_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    rstart_d = rstart_q;
    cstart_d = cstart_q;
    if (restart_i) begin
      row_d    = '0;
      col_d    = '0;
      chan_d   = '0;
      wrow_d   = '0;
      wcol_d   = '0;
      orow_d   = '0;
      ocol_d   = '0;
      rstart_d = '0;
      cstart_d = '0;
    end else if (step_i) begin
      if (chan_last) begin
        chan_d = '0;
        col_d  = col_q + 1'b1;
        if (col_in) begin
          if (wcol_last) begin
            wcol_d   = '0;
            ocol_d   = ocol_q + 1'b1;
            cstart_d = cstart_q + COL_W'(cfg_i.pcol);
          end else begin
            wcol_d = wcol_q + 1'b1;
          end
        end
        if (col_last) begin
          col_d    = '0;
          wcol_d   = '0;
          ocol_d   = '0;
          cstart_d = '0;
          row_d    = row_q + 1'b1;
          if (row_in) begin
            if (wrow_last) begin
              wrow_d   = '0;
              orow_d   = orow_q + 1'b1;
              rstart_d = rstart_q + ROW_W'(cfg_i.prow);
            end else begin
              wrow_d = wrow_q + 1'b1;
            end
          end
          // frame end: everything back to the origin
          if (row_last) begin
            row_d    = '0;
            wrow_d   = '0;
            orow_d   = '0;
            rstart_d = '0;
          end
        end
      end else begin
        chan_d = chan_q + 1'b1;
      end
    end
  end

  // counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      chan_q   <= '0;
      wrow_q   <= '0;
      wcol_q   <= '0;
      orow_q   <= '0;
      ocol_q   <= '0;
      rstart_q <= '0;
      cstart_q <= '0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      chan_q   <= chan_d;
      wrow_q   <= wrow_d;
      wcol_q   <= wcol_d;
      orow_q   <= orow_d;
      ocol_q   <= ocol_d;
      rstart_q <= rstart_d;
      cstart_q <= cstart_d;
    end
  end

endmodule

[rtl/max_pool_2d_stream_core.sv]
// streaming 2-d max pooling core, hwc order, q8.8 samples
// result path: the closing request passes the update stage, then the result queue
// throughput: one sample per cycle while ready; partial maxima live in one ram
//   read at accept and written back the next cycle (bypass on back-to-back hits)
// reset: counters cleared, configuration 32x32x1 with 2x2 windows, ram not cleared
// depends on mp2d_pkg, mp2d_ram, mp2d_scan
module max_pool_2d_stream_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [mp2d_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [mp2d_pkg::CFG_DW-1:0]   cfg_wdata_i,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [mp2d_pkg::DATA_W-1:0] sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [mp2d_pkg::DATA_W-1:0] pooled_o,
  output logic [mp2d_pkg::OROW_W-1:0]   out_row_o,
  output logic [mp2d_pkg::OCOL_W-1:0]   out_col_o,
  output logic [mp2d_pkg::CHAN_W-1:0]   channel_o,
  output logic                          frame_end_o
);
  import mp2d_pkg::*;

  cfg_t cfg_q;
  logic restart;

  logic [ROW_W-1:0]      wr_height;
  logic [COL_W-1:0]      wr_width;
  logic [CHAN_CNT_W-1:0] wr_chans;
  logic [POOL_W-1:0]     wr_pool;

  // truncate written values to their field widths, then saturate into legal ranges
  always_comb begin
    wr_height = cfg_wdata_i[ROW_W-1:0];
    wr_width  = cfg_wdata_i[COL_W-1:0];
    wr_chans  = cfg_wdata_i[CHAN_CNT_W-1:0];
    wr_pool   = cfg_wdata_i[POOL_W-1:0];
    if (wr_height == '0) begin
      wr_height = ROW_W'(1);
    end else if (wr_height > ROW_W'(MAX_HEIGHT)) begin
      wr_height = ROW_W'(MAX_HEIGHT);
    end
    if (wr_width == '0) begin
      wr_width = COL_W'(1);
    end else if (wr_width > COL_W'(MAX_WIDTH)) begin
      wr_width = COL_W'(MAX_WIDTH);
    end
    if (wr_chans == '0) begin
      wr_chans = CHAN_CNT_W'(1);
    end else if (wr_chans > CHAN_CNT_W'(MAX_CHANNELS)) begin
      wr_chans = CHAN_CNT_W'(MAX_CHANNELS);
    end
    if (wr_pool == '0) begin
      wr_pool = POOL_W'(1);
    end else if (wr_pool > POOL_W'(MAX_POOL)) begin
      wr_pool = POOL_W'(MAX_POOL);
    end
  end

  // a write to a known register restarts the frame
  always_comb begin
    unique case (reg_idx_e'(cfg_index_i))
      REG_IN_HEIGHT, REG_IN_WIDTH, REG_CHANNELS,
      REG_POOL_ROWS, REG_POOL_COLS: restart = cfg_we_i;
      default:                      restart = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height <= ROW_W'(32);
      cfg_q.width  <= COL_W'(32);
      cfg_q.chans  <= CHAN_CNT_W'(1);
      cfg_q.prow   <= POOL_W'(2);
      cfg_q.pcol   <= POOL_W'(2);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_IN_HEIGHT: cfg_q.height <= wr_height;
        REG_IN_WIDTH:  cfg_q.width  <= wr_width;
        REG_CHANNELS:  cfg_q.chans  <= wr_chans;
        REG_POOL_ROWS: cfg_q.prow   <= wr_pool;
        REG_POOL_COLS: cfg_q.pcol   <= wr_pool;
        default: ;
      endcase
    end
  end

  // stream position
  pos_t pos;
  logic in_accept, issue;

  assign in_accept = in_valid_i & in_ready_o;
  assign issue     = in_accept & pos.in_win;

  mp2d_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (restart),
    .step_i    (in_accept),
    .pos_o     (pos)
  );

  // update stage registers
  logic                     s1_valid_q;
  logic                     s1_first_q;
  logic                     s1_last_q;
  logic                     s1_fend_q;
  logic signed [DATA_W-1:0] s1_sample_q;
  logic [MEM_AW-1:0]        s1_addr_q;
  logic [OROW_W-1:0]        s1_orow_q;
  logic [OCOL_W-1:0]        s1_ocol_q;
  logic [CHAN_W-1:0]        s1_chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_first_q  <= pos.first;
      s1_last_q   <= pos.last_win;
      s1_fend_q   <= pos.frame_end;
      s1_sample_q <= sample_i;
      s1_addr_q   <= {pos.ocol, pos.chan};
      s1_orow_q   <= pos.orow;
      s1_ocol_q   <= pos.ocol;
      s1_chan_q   <= pos.chan;
    end
  end

  // partial maximum memory
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] cur_max;
  logic signed [DATA_W-1:0] new_max;

  mp2d_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (new_max),
    .re_i    (issue),
    .raddr_i ({pos.ocol, pos.chan}),
    .rdata_o (rd_data)
  );

  // bypass of the write that collided with this entry's read
  logic              fwd_valid_q;
  logic [MEM_AW-1:0] fwd_addr_q;
  logic [DATA_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_max;
    end
  end

  // read-modify-write: first sample of a window overwrites
  always_comb begin
    cur_max = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? $signed(fwd_data_q)
                                                         : $signed(rd_data);
    new_max = (s1_first_q || (s1_sample_q > cur_max)) ? s1_sample_q : cur_max;
  end

  // result queue
  res_t              fifo_q [OUT_DEPTH];
  logic [OPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OCNT_W-1:0] cnt_q;
  logic              push, pop;
  res_t              push_res;

  assign push = s1_valid_q & s1_last_q;
  assign pop  = out_valid_o & out_ready_i;

  assign push_res.pooled    = new_max;
  assign push_res.orow      = s1_orow_q;
  assign push_res.ocol      = s1_ocol_q;
  assign push_res.chan      = s1_chan_q;
  assign push_res.frame_end = s1_fend_q;

  // room is reserved for the request already in the update stage
  assign in_ready_o  = ((OCNT_W + 1)'(cnt_q) + (OCNT_W + 1)'(s1_valid_q))
                       < (OCNT_W + 1)'(OUT_DEPTH);
  assign out_valid_o = cnt_q != '0;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      priority if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        cnt_q <= cnt_q;
      end
    end
  end

  // result outputs
  assign pooled_o    = $signed(fifo_q[rd_ptr_q].pooled);
  assign out_row_o   = fifo_q[rd_ptr_q].orow;
  assign out_col_o   = fifo_q[rd_ptr_q].ocol;
  assign channel_o   = fifo_q[rd_ptr_q].chan;
  assign frame_end_o = fifo_q[rd_ptr_q].frame_end;

endmodule

[rtl/mp2d_checker.sv]
// port-level checks for the max pooling core, bound to the top level
// depends on mp2d_pkg and max_pool_2d_stream_core_defines.svh
`include "max_pool_2d_stream_core_defines.svh"

module mp2d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [mp2d_pkg::DATA_W-1:0] pooled_o,
  input logic [mp2d_pkg::OROW_W-1:0]   out_row_o,
  input logic [mp2d_pkg::OCOL_W-1:0]   out_col_o,
  input logic [mp2d_pkg::CHAN_W-1:0]   channel_o,
  input logic                          frame_end_o
);

  // stalled result holds
  `MP2D_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(pooled_o) && $stable(out_row_o)
      && $stable(out_col_o) && $stable(channel_o) && $stable(frame_end_o),
    "stalled result changed")

  // a new result follows an earlier accepted request
  `MP2D_ASSERT_NOW(a_out_cause, $rose(out_valid_o),
    $past(in_valid_i && in_ready_o, 2), "result without a request")

  // the input only stalls while a result is pending
  `MP2D_ASSERT_NOW(a_no_deadlock, !in_ready_o, out_valid_o,
    "input stalled with no result pending")

endmodule

bind max_pool_2d_stream_core mp2d_checker u_checker (.*);
